### hw/rtl/source_text_tokenizer_defines.svh
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define STT_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define STT_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

### hw/rtl/stt_pkg.sv
package stt_pkg;

	localparam int MAX_RUN_CHARS = 32;
	localparam int CHAR_W = 8;
	localparam int KIND_W = 3;
	localparam int MODE_W = 2;
	localparam int ADDR_W = $clog2(MAX_RUN_CHARS);
	localparam int LEN_W = $clog2(MAX_RUN_CHARS + 1);

	localparam logic [KIND_W-1:0] KIND_IDENT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_KEYWORD = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DELIMITER = 3'd4;
	localparam logic [KIND_W-1:0] KIND_EOF = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd6;

	localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_IDENT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NUMBER = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_EOT = 8'h00;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [CHAR_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	function automatic logic is_letter(logic [CHAR_W-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(logic [CHAR_W-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(logic [CHAR_W-1:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_operator(logic [CHAR_W-1:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "=";
	endfunction

	function automatic logic is_delimiter(logic [CHAR_W-1:0] c);
		return c == "(" || c == ")" || c == ";";
	endfunction

	function automatic logic [CHAR_W-1:0] kw_int_char(logic [LEN_W-1:0] i);
		logic [CHAR_W-1:0] r;
		unique case (i)
			LEN_W'(0): r = "i";
			LEN_W'(1): r = "n";
			LEN_W'(2): r = "t";
			default:   r = CHAR_EOT;
		endcase
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] kw_print_char(logic [LEN_W-1:0] i);
		logic [CHAR_W-1:0] r;
		unique case (i)
			LEN_W'(0): r = "p";
			LEN_W'(1): r = "r";
			LEN_W'(2): r = "i";
			LEN_W'(3): r = "n";
			LEN_W'(4): r = "t";
			default:   r = CHAR_EOT;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/stt_char_if.sv
interface stt_char_if;
	import stt_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

### hw/rtl/stt_token_if.sv
interface stt_token_if;
	import stt_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] char_out;
	logic              last;
	logic              truncated;

	modport source (output valid, output kind, output char_out, output last,
		output truncated, input ready);
	modport sink (input valid, input kind, input char_out, input last,
		input truncated, output ready);
endinterface

### hw/rtl/stt_run_mem.sv
module stt_run_mem (
	input  logic                     clk,
	input  stt_pkg::mem_req_t        mem_req,
	output logic [stt_pkg::CHAR_W-1:0] rd_data
);
	import stt_pkg::*;

	logic [CHAR_W-1:0] mem [MAX_RUN_CHARS];

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_data <= mem[mem_req.rd_addr];
		end
	end
endmodule

### hw/rtl/stt_scanner.sv
module stt_scanner (
	input  logic                       clk,
	input  logic                       arst_n,
	stt_char_if.sink                   chars,
	stt_token_if.source                tokens,
	output stt_pkg::mem_req_t          mem_req,
	input  logic [stt_pkg::CHAR_W-1:0] rd_data
);
	import stt_pkg::*;

	typedef enum logic [3:0] {
		ST_SCAN = 4'b0001,
		ST_READ = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_PEND = 4'b1000
	} state_t;

	state_t            state_q;
	logic [MODE_W-1:0] mode_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  idx_q;
	logic              ovf_q;
	logic              int_ok_q;
	logic              print_ok_q;
	logic [CHAR_W-1:0] pend_q;

	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              trunc_q;

	logic              out_free;
	logic              in_run;
	logic              accept;
	logic [CHAR_W-1:0] c;
	logic              cont;
	logic [CHAR_W-1:0] b;
	logic              b_quiet;
	logic              b_starts;
	logic              do_idle;
	logic              do_append;
	logic              do_end;
	logic              emit;
	logic              last_char;
	logic              is_kw;
	logic [KIND_W-1:0] run_kind;
	logic [KIND_W-1:0] single_kind;
	logic              room;
	logic              load_single;

	assign out_free = !out_valid_q || tokens.ready;
	assign in_run = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
	assign chars.ready = (state_q == ST_SCAN) && out_free;
	assign accept = chars.valid && chars.ready;
	assign c = chars.char_in;
	assign cont = ((mode_q == MODE_IDENT) && (is_letter(c) || is_digit(c)))
		|| ((mode_q == MODE_NUMBER) && is_digit(c));

	// byte handled as if idle: fresh input, or the one that closed a run
	assign b = (state_q == ST_PEND) ? pend_q : c;
	assign b_starts = is_letter(b) || is_digit(b);
	assign b_quiet = is_space(b) || b_starts;

	assign do_idle = (accept && !in_run) || ((state_q == ST_PEND) && (b_quiet || out_free));
	assign do_append = accept && cont;
	assign do_end = accept && in_run && !cont;
	assign emit = (state_q == ST_EMIT) && out_free;
	assign load_single = do_idle && !b_quiet;

	assign room = len_q < LEN_W'(MAX_RUN_CHARS);
	assign last_char = (idx_q + LEN_W'(1)) == len_q;
	assign is_kw = !ovf_q && (((len_q == LEN_W'(3)) && int_ok_q)
		|| ((len_q == LEN_W'(5)) && print_ok_q));
	assign run_kind = (mode_q == MODE_IDENT) ? (is_kw ? KIND_KEYWORD : KIND_IDENT)
		: KIND_NUMBER;

	always_comb begin
		priority if (b == CHAR_EOT) begin
			single_kind = KIND_EOF;
		end else if (is_operator(b)) begin
			single_kind = KIND_OPERATOR;
		end else if (is_delimiter(b)) begin
			single_kind = KIND_DELIMITER;
		end else begin
			single_kind = KIND_UNKNOWN;
		end
	end

	always_comb begin
		mem_req.wr_en = (do_idle && b_starts) || (do_append && room);
		mem_req.wr_addr = do_append ? len_q[ADDR_W-1:0] : '0;
		mem_req.wr_data = b;
		mem_req.rd_en = (state_q == ST_READ);
		mem_req.rd_addr = idx_q[ADDR_W-1:0];
	end

	assign tokens.valid = out_valid_q;
	assign tokens.kind = kind_q;
	assign tokens.char_out = char_q;
	assign tokens.last = last_q;
	assign tokens.truncated = trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
			mode_q <= MODE_IDLE;
			len_q <= '0;
			idx_q <= '0;
			ovf_q <= 1'b0;
			int_ok_q <= 1'b0;
			print_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_single || emit) begin
				out_valid_q <= 1'b1;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_SCAN: begin
					if (do_append) begin
						if (room) begin
							len_q <= len_q + LEN_W'(1);
							int_ok_q <= int_ok_q && (c == kw_int_char(len_q));
							print_ok_q <= print_ok_q && (c == kw_print_char(len_q));
						end else begin
							ovf_q <= 1'b1;
						end
					end else if (do_end) begin
						idx_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						if (last_char) begin
							mode_q <= MODE_IDLE;
							len_q <= '0;
							ovf_q <= 1'b0;
							state_q <= ST_PEND;
						end else begin
							idx_q <= idx_q + LEN_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_PEND: begin
					if (do_idle) begin
						state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_SCAN;
				end
			endcase

			if (do_idle) begin
				if (b == CHAR_EOT) begin
					mode_q <= MODE_IDLE;
					len_q <= '0;
					ovf_q <= 1'b0;
				end else if (b_starts) begin
					mode_q <= is_letter(b) ? MODE_IDENT : MODE_NUMBER;
					len_q <= LEN_W'(1);
					ovf_q <= 1'b0;
					int_ok_q <= (b == kw_int_char('0));
					print_ok_q <= (b == kw_print_char('0));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_end) begin
			pend_q <= c;
		end
		if (emit) begin
			kind_q <= run_kind;
			char_q <= rd_data;
			last_q <= last_char;
			trunc_q <= ovf_q;
		end else if (load_single) begin
			kind_q <= single_kind;
			char_q <= b;
			last_q <= 1'b1;
			trunc_q <= 1'b0;
		end
	end
endmodule

### hw/rtl/source_text_tokenizer.sv
// Source text tokenizer: takes one byte per word on chars (zero ends the text) and
// sends tokens on tokens, one character per word, with last on the final character.
// Identifiers, keywords (int, print) and numbers are collected in a 32-entry run
// buffer memory and replayed when the byte after the run arrives; operators,
// delimiters, unknown bytes and end of text give one word each. Runs longer than
// 32 characters keep their first 32 and come out with truncated set. A byte that
// extends a run or yields a single word is taken whenever the output register
// is free. A run is replayed one character at a time: a registered read of the
// run buffer (ST_READ), then an output load (ST_EMIT) that waits while the
// output register is full. The byte that closed the run is then handled in
// ST_PEND. No clearing pass follows reset.
`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer (
	input logic         clk,
	input logic         arst_n,
	stt_char_if.sink    chars,
	stt_token_if.source tokens
);
	import stt_pkg::*;

	mem_req_t          mem_req;
	logic [CHAR_W-1:0] rd_data;

	stt_scanner u_scanner (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.tokens  (tokens),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	stt_run_mem u_run_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	`STT_ASSERT_NOW(a_no_rw_overlap, mem_req.wr_en, !mem_req.rd_en)
	`STT_ASSERT_NEXT(a_read_then_no_write, mem_req.rd_en, !mem_req.wr_en)
	`STT_ASSERT_NOW(a_accept_slot_free, chars.valid && chars.ready, !tokens.valid || tokens.ready)
	`STT_ASSERT_NOW(a_eof_word, tokens.valid && (tokens.kind == KIND_EOF), tokens.last && (tokens.char_out == CHAR_EOT) && !tokens.truncated)
endmodule

### tb/token_checker.sv
`timescale 1ns / 1ps

module token_checker (
	input  logic        clk,
	input  logic        arst_n,
	stt_char_if         chars,
	stt_token_if        tokens,
	output int unsigned pending,
	output int unsigned fail_count
);
	import stt_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] text;
		logic              last;
		logic              truncated;
	} token_word_t;

	typedef enum logic [2:0] {
		CL_END, CL_BLANK, CL_LETTER, CL_DIGIT, CL_OPER, CL_DELIM, CL_OTHER
	} byte_class_t;

	token_word_t       expected_words [$];
	logic [MODE_W-1:0] mode = MODE_IDLE;
	logic [CHAR_W-1:0] run_buf [MAX_RUN_CHARS];
	int unsigned       run_len = 0;
	logic              run_cut = 1'b0;
	int unsigned       errors = 0;

	function automatic byte_class_t classify(logic [CHAR_W-1:0] c);
		if (c == CHAR_EOT)
			return CL_END;
		if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13))
			return CL_BLANK;
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
			return CL_LETTER;
		if (c >= "0" && c <= "9")
			return CL_DIGIT;
		if (c == "+" || c == "-" || c == "*" || c == "/" || c == "=")
			return CL_OPER;
		if (c == "(" || c == ")" || c == ";")
			return CL_DELIM;
		return CL_OTHER;
	endfunction

	function automatic logic run_is_keyword();
		if (run_cut)
			return 1'b0;
		if (run_len == 3)
			return {run_buf[0], run_buf[1], run_buf[2]} == "int";
		if (run_len == 5)
			return {run_buf[0], run_buf[1], run_buf[2], run_buf[3], run_buf[4]} == "print";
		return 1'b0;
	endfunction

	task automatic push_word(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] text, logic last,
		logic truncated);
		token_word_t w;
		w.kind = kind;
		w.text = text;
		w.last = last;
		w.truncated = truncated;
		expected_words.push_back(w);
	endtask

	task automatic add_char(logic [CHAR_W-1:0] c);
		if (run_len < MAX_RUN_CHARS) begin
			run_buf[run_len] = c;
			run_len++;
		end else begin
			run_cut = 1'b1;
		end
	endtask

	task automatic flush_run();
		logic [KIND_W-1:0] kind;
		if (mode == MODE_IDENT)
			kind = run_is_keyword() ? KIND_KEYWORD : KIND_IDENT;
		else
			kind = KIND_NUMBER;
		for (int i = 0; i < run_len; i++)
			push_word(kind, run_buf[i], i + 1 == run_len, run_cut);
		mode = MODE_IDLE;
		run_len = 0;
		run_cut = 1'b0;
	endtask

	task automatic predict_tokens(logic [CHAR_W-1:0] c);
		byte_class_t cls;
		cls = classify(c);
		if (mode == MODE_IDENT && (cls == CL_LETTER || cls == CL_DIGIT)) begin
			add_char(c);
			return;
		end
		if (mode == MODE_NUMBER && cls == CL_DIGIT) begin
			add_char(c);
			return;
		end
		if (mode == MODE_IDENT || mode == MODE_NUMBER)
			flush_run();
		mode = MODE_IDLE;
		case (cls)
			CL_END: push_word(KIND_EOF, CHAR_EOT, 1'b1, 1'b0);
			CL_LETTER: begin
				mode = MODE_IDENT;
				add_char(c);
			end
			CL_DIGIT: begin
				mode = MODE_NUMBER;
				add_char(c);
			end
			CL_OPER: push_word(KIND_OPERATOR, c, 1'b1, 1'b0);
			CL_DELIM: push_word(KIND_DELIMITER, c, 1'b1, 1'b0);
			CL_OTHER: push_word(KIND_UNKNOWN, c, 1'b1, 1'b0);
			default: ;
		endcase
	endtask

	task automatic check_field(string name, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
		if (got !== want) begin
			errors++;
			$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		token_word_t want;
		if (arst_n) begin
			if (chars.valid && chars.ready)
				predict_tokens(chars.char_in);
			if (tokens.valid && tokens.ready) begin
				if (expected_words.size() == 0) begin
					errors++;
					$error("unexpected token word: kind %0h char %0h", tokens.kind,
						tokens.char_out);
				end else begin
					want = expected_words.pop_front();
					check_field("kind", CHAR_W'(want.kind), CHAR_W'(tokens.kind));
					check_field("char_out", want.text, tokens.char_out);
					check_field("last", CHAR_W'(want.last), CHAR_W'(tokens.last));
					check_field("truncated", CHAR_W'(want.truncated), CHAR_W'(tokens.truncated));
				end
			end
		end
		pending <= expected_words.size();
		fail_count <= errors;
	end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import stt_pkg::*;

	localparam int BYTE_TARGET = 210;
	localparam int GAP_MAX = 11;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned pending;
	int unsigned fail_count;
	int unsigned bytes_sent = 0;
	logic        source_calm = 1'b0;
	logic        sink_calm = 1'b0;

	logic [CHAR_W-1:0] opening [25] = '{"i", "n", "t", 8'd9, "p", "r", "i", "n", "t", "(",
		"Z", "9", "-", "7", ")", "*", "/", "+", "=", ";", "#", 8'hff, "x", CHAR_EOT, CHAR_EOT};
	string near_words [8] = '{"int", "print", "in", "prin", "intx", "printf", "Int", "pr1nt"};
	string oper_chars = "+-*/=";
	string delim_chars = "();";

	stt_char_if chars ();
	stt_token_if tokens ();

	source_text_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.tokens(tokens)
	);

	token_checker token_check (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.tokens(tokens),
		.pending(pending),
		.fail_count(fail_count)
	);

	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("source_text_tokenizer test failed");
		$finish;
	end

	// token sink with random stalls per word
	initial begin
		int stall;
		tokens.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				tokens.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tokens.ready <= 1'b1;
			@(posedge clk);
			while (!tokens.valid) @(posedge clk);
		end
	end

	task automatic send_byte(logic [CHAR_W-1:0] b);
		int gap;
		gap = source_calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars.valid <= 1'b1;
		chars.char_in <= b;
		@(posedge clk);
		while (!chars.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic wait_for_tokens();
		chars.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [CHAR_W-1:0] random_letter();
		logic [CHAR_W-1:0] base;
		base = $urandom_range(0, 1) ? "a" : "A";
		return base + CHAR_W'($urandom_range(0, 25));
	endfunction

	function automatic logic [CHAR_W-1:0] random_digit();
		return "0" + CHAR_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [CHAR_W-1:0] random_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? 8'd32 : CHAR_W'(9 + r);
	endfunction

	task automatic send_run(logic ident, int len);
		for (int i = 0; i < len; i++) begin
			if (!ident)
				send_byte(random_digit());
			else if (i == 0 || $urandom_range(0, 3) != 0)
				send_byte(random_letter());
			else
				send_byte(random_digit());
		end
	endtask

	task automatic send_separator();
		case ($urandom_range(0, 4))
			0: ;
			1: send_byte(oper_chars[$urandom_range(0, 4)]);
			2: send_byte(delim_chars[$urandom_range(0, 2)]);
			default: send_byte(random_blank());
		endcase
	endtask

	function automatic int random_run_len();
		return ($urandom_range(0, 29) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
	endfunction

	task automatic send_random_token();
		int    pick;
		string w;
		if ($urandom_range(0, 14) == 0)
			source_calm = ~source_calm;
		if ($urandom_range(0, 14) == 0)
			sink_calm = ~sink_calm;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			send_run(1'b1, random_run_len());
			send_separator();
		end else if (pick < 32) begin
			w = near_words[$urandom_range(0, 7)];
			for (int i = 0; i < w.len(); i++)
				send_byte(w[i]);
			send_separator();
		end else if (pick < 50) begin
			send_run(1'b0, random_run_len());
			send_separator();
		end else if (pick < 62) begin
			send_byte(oper_chars[$urandom_range(0, 4)]);
		end else if (pick < 70) begin
			send_byte(delim_chars[$urandom_range(0, 2)]);
		end else if (pick < 80) begin
			send_byte(random_blank());
		end else if (pick < 88) begin
			send_byte(CHAR_W'($urandom_range(0, 255)));
		end else if (pick < 94) begin
			send_byte(CHAR_W'($urandom_range(128, 255)));
		end else begin
			send_byte(CHAR_EOT);
		end
	endtask

	initial begin
		logic drained;
		drained = 1'b0;
		arst_n <= 1'b0;
		chars.valid <= 1'b0;
		chars.char_in <= CHAR_EOT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			send_byte(opening[i]);
		wait_for_tokens();
		// overlong runs, cut at the buffer size
		send_run(1'b1, $urandom_range(33, 36));
		send_byte(";");
		send_run(1'b0, $urandom_range(33, 36));
		send_byte(CHAR_EOT);
		while (bytes_sent < BYTE_TARGET) begin
			if (!drained && bytes_sent >= BYTE_TARGET * 2 / 3) begin
				wait_for_tokens();
				drained = 1'b1;
			end
			send_random_token();
		end
		send_byte(CHAR_EOT);
		wait_for_tokens();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("source_text_tokenizer test passed");
		else
			$display("source_text_tokenizer test failed");
		$finish;
	end
endmodule
